// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the top-level design file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/csc_pkg.sv =====
// ---------------------------------------------------------------------------
// csc_pkg
// Widths, register codes and pipeline types of the color matrix.
// ---------------------------------------------------------------------------
package csc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int NPLANE     = 3;
  localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
  localparam int OFFSET_W   = 32;
  localparam int ACC_W      = PROD_W + 3;
  localparam int SHIFT_W    = 5;
  localparam int DEPTH_W    = 5;
  localparam int MIN_DEPTH  = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = NPLANE * COEF_W;
  localparam int DATA_W     = NPLANE * SAMPLE_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_ROW0    = 3'd0,
    REG_COEF_ROW1    = 3'd1,
    REG_COEF_ROW2    = 3'd2,
    REG_OFFSET_ROW0  = 3'd3,
    REG_OFFSET_ROW1  = 3'd4,
    REG_OFFSET_ROW2  = 3'd5,
    REG_SOURCE_DEPTH = 3'd6,
    REG_DEST_DEPTH   = 3'd7
  } cfg_reg_t;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NPLANE-1:0] pixel_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NPLANE-1:0][NPLANE-1:0] coef_mat_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef offset_t [NPLANE-1:0] offset_vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [NPLANE-1:0][NPLANE-1:0] prod_mat_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef acc_t [NPLANE-1:0] acc_vec_t;

  typedef struct packed {
    logic vld;
    logic last;
  } pipe_ctl_t;

  typedef struct packed {
    logic [SHIFT_W-1:0]  sh;
    logic [SAMPLE_W-1:0] maxv;
  } scale_t;

endpackage

// ===== design/csc_mult_stage.sv =====
// ---------------------------------------------------------------------------
// csc_mult_stage
// First stage: nine sample-by-coefficient products.
// ---------------------------------------------------------------------------
module csc_mult_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  csc_pkg::pipe_ctl_t  up_ctl,
  input  csc_pkg::pixel_t     up_pix,
  output logic                up_ready,
  input  csc_pkg::coef_mat_t  coef,
  output csc_pkg::pipe_ctl_t  dn_ctl,
  output csc_pkg::prod_mat_t  dn_prod,
  input  logic                dn_ready
);
  import csc_pkg::*;

  pipe_ctl_t ctl_r;
  prod_mat_t prod_r;
  prod_mat_t prod_nxt;

  assign up_ready = !ctl_r.vld || dn_ready;

  always_comb begin
    for (int p = 0; p < NPLANE; p++) begin
      for (int i = 0; i < NPLANE; i++) begin
        prod_nxt[p][i] = $signed({1'b0, up_pix[i]}) * $signed(coef[p][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
    if (up_ready && up_ctl.vld) begin
      prod_r <= prod_nxt;
    end
  end

  assign dn_ctl  = ctl_r;
  assign dn_prod = prod_r;

endmodule

// ===== design/csc_sum_stage.sv =====
// ---------------------------------------------------------------------------
// csc_sum_stage
// Second stage: per-plane sum of products plus row offset.
// ---------------------------------------------------------------------------
module csc_sum_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csc_pkg::pipe_ctl_t   up_ctl,
  input  csc_pkg::prod_mat_t   up_prod,
  output logic                 up_ready,
  input  csc_pkg::offset_vec_t offset,
  output csc_pkg::pipe_ctl_t   dn_ctl,
  output csc_pkg::acc_vec_t    dn_acc,
  input  logic                 dn_ready
);
  import csc_pkg::*;

  pipe_ctl_t ctl_r;
  acc_vec_t  acc_r;
  acc_vec_t  acc_nxt;

  assign up_ready = !ctl_r.vld || dn_ready;

  always_comb begin
    for (int p = 0; p < NPLANE; p++) begin
      acc_nxt[p] = ACC_W'($signed(up_prod[p][0])) + ACC_W'($signed(up_prod[p][1]))
                 + ACC_W'($signed(up_prod[p][2])) + ACC_W'($signed(offset[p]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
    if (up_ready && up_ctl.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign dn_ctl = ctl_r;
  assign dn_acc = acc_r;

endmodule

// ===== design/csc_clamp_stage.sv =====
// ---------------------------------------------------------------------------
// csc_clamp_stage
// Third stage: floor shift to destination depth and clamp; output register.
// ---------------------------------------------------------------------------
module csc_clamp_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  csc_pkg::pipe_ctl_t up_ctl,
  input  csc_pkg::acc_vec_t  up_acc,
  output logic               up_ready,
  input  csc_pkg::scale_t    scale,
  output csc_pkg::pipe_ctl_t dn_ctl,
  output csc_pkg::pixel_t    dn_pix,
  input  logic               dn_ready
);
  import csc_pkg::*;

  pipe_ctl_t ctl_r;
  pixel_t    pix_r;
  pixel_t    pix_nxt;
  acc_t      shifted;

  assign up_ready = !ctl_r.vld || dn_ready;

  always_comb begin
    shifted = '0;
    for (int p = 0; p < NPLANE; p++) begin
      shifted = up_acc[p] >>> scale.sh;
      if (shifted[ACC_W-1]) begin
        pix_nxt[p] = '0;
      end else if ($unsigned(shifted) > ACC_W'(scale.maxv)) begin
        pix_nxt[p] = scale.maxv;
      end else begin
        pix_nxt[p] = shifted[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
    if (up_ready && up_ctl.vld) begin
      pix_r <= pix_nxt;
    end
  end

  assign dn_ctl = ctl_r;
  assign dn_pix = pix_r;

endmodule

// ===== design/color_matrix_3x4_fixed_point.sv =====
// ---------------------------------------------------------------------------
// color_matrix_3x4_fixed_point
// A pixel accepted at the input passes through the multiply, sum and clamp
// registers before it is shown on the output.
// Throughput: one pixel per clock; a stalled output holds the pipeline and
// bubbles in it are filled while it stalls.
// Reset: synchronous, active low; clears valid bits and configuration
// (coefficients and offsets to zero, both depths to 8).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module color_matrix_3x4_fixed_point #(
  parameter int COEF_FRAC_BITS  = 12,
  parameter int MAX_SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [csc_pkg::DATA_W-1:0]         in_tdata,   // in_sample_0, in_sample_1, in_sample_2
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [csc_pkg::DATA_W-1:0]         out_tdata,  // out_sample_0, out_sample_1, out_sample_2
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [csc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [csc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import csc_pkg::*;

  coef_mat_t            coef_r;
  offset_vec_t          offset_r;
  logic [DEPTH_W-1:0]   source_depth_r;
  logic [DEPTH_W-1:0]   dest_depth_r;
  scale_t               scale_r;
  scale_t               scale_nxt;
  logic [DEPTH_W-1:0]   sd_sat;
  logic [DEPTH_W-1:0]   dd_sat;

  pipe_ctl_t            in_ctl;
  pixel_t               in_pix;
  pipe_ctl_t            s1_ctl;
  prod_mat_t            s1_prod;
  logic                 s2_ready;
  pipe_ctl_t            s2_ctl;
  acc_vec_t             s2_acc;
  logic                 s3_ready;
  pipe_ctl_t            s3_ctl;
  pixel_t               s3_pix;
  logic [1:0]           occ_cnt;
  logic [1:0]           occ_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r         <= '0;
      offset_r       <= '0;
      source_depth_r <= DEPTH_W'(MIN_DEPTH);
      dest_depth_r   <= DEPTH_W'(MIN_DEPTH);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_COEF_ROW0:    coef_r[0] <= cfg_wdata;
        REG_COEF_ROW1:    coef_r[1] <= cfg_wdata;
        REG_COEF_ROW2:    coef_r[2] <= cfg_wdata;
        REG_OFFSET_ROW0:  offset_r[0] <= cfg_wdata[OFFSET_W-1:0];
        REG_OFFSET_ROW1:  offset_r[1] <= cfg_wdata[OFFSET_W-1:0];
        REG_OFFSET_ROW2:  offset_r[2] <= cfg_wdata[OFFSET_W-1:0];
        REG_SOURCE_DEPTH: source_depth_r <= cfg_wdata[DEPTH_W-1:0];
        REG_DEST_DEPTH:   dest_depth_r <= cfg_wdata[DEPTH_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (source_depth_r < DEPTH_W'(MIN_DEPTH)) begin
      sd_sat = DEPTH_W'(MIN_DEPTH);
    end else if (source_depth_r > DEPTH_W'(MAX_SAMPLE_BITS)) begin
      sd_sat = DEPTH_W'(MAX_SAMPLE_BITS);
    end else begin
      sd_sat = source_depth_r;
    end
    if (dest_depth_r < DEPTH_W'(MIN_DEPTH)) begin
      dd_sat = DEPTH_W'(MIN_DEPTH);
    end else if (dest_depth_r > DEPTH_W'(MAX_SAMPLE_BITS)) begin
      dd_sat = DEPTH_W'(MAX_SAMPLE_BITS);
    end else begin
      dd_sat = dest_depth_r;
    end
    scale_nxt.sh   = SHIFT_W'(COEF_FRAC_BITS) + SHIFT_W'(sd_sat) - SHIFT_W'(dd_sat);
    scale_nxt.maxv = ~({SAMPLE_W{1'b1}} << dd_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  assign in_ctl.vld  = in_tvalid;
  assign in_ctl.last = in_tlast;

  always_comb begin
    for (int i = 0; i < NPLANE; i++) begin
      in_pix[i] = in_tdata[i*SAMPLE_W +: SAMPLE_W];
    end
  end

  csc_mult_stage u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (in_ctl),
    .up_pix   (in_pix),
    .up_ready (in_tready),
    .coef     (coef_r),
    .dn_ctl   (s1_ctl),
    .dn_prod  (s1_prod),
    .dn_ready (s2_ready)
  );

  csc_sum_stage u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (s1_ctl),
    .up_prod  (s1_prod),
    .up_ready (s2_ready),
    .offset   (offset_r),
    .dn_ctl   (s2_ctl),
    .dn_acc   (s2_acc),
    .dn_ready (s3_ready)
  );

  csc_clamp_stage u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (s2_ctl),
    .up_acc   (s2_acc),
    .up_ready (s3_ready),
    .scale    (scale_r),
    .dn_ctl   (s3_ctl),
    .dn_pix   (s3_pix),
    .dn_ready (out_tready)
  );

  assign out_tvalid = s3_ctl.vld;
  assign out_tlast  = s3_ctl.last;

  always_comb begin
    for (int i = 0; i < NPLANE; i++) begin
      out_tdata[i*SAMPLE_W +: SAMPLE_W] = s3_pix[i];
    end
  end

  assign occ_cnt  = {1'b0, s1_ctl.vld} + {1'b0, s2_ctl.vld} + {1'b0, s3_ctl.vld};
  assign occ_step = occ_cnt + {1'b0, in_tvalid && in_tready}
                  - {1'b0, out_tvalid && out_tready};

  `ASSERT_IMPL(a_drain_opens_input, clk, rst_n, out_tready, in_tready)
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_tvalid && in_tready, s1_ctl.vld)
  `ASSERT_NEXT(a_no_loss_no_dup, clk, rst_n, 1'b1, occ_cnt == $past(occ_step))

endmodule

// ===== tb/tb_color_matrix_3x4_fixed_point.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_color_matrix_3x4_fixed_point
// Streams pixels through the 3x4 fixed-point color matrix and compares every
// output pixel with a local model of the matrix, shift and clamp. A short
// table of pixels and register writes comes first, with the values that are
// obvious typed in. Eight random phases follow, each with a fresh register
// setting and one of four patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_color_matrix_3x4_fixed_point;
  import csc_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int FRAC_BITS    = 12;
  localparam int MAX_DEPTH    = 16;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_REQS   = 204;

  typedef struct packed {
    pixel_t smp;
    logic   last;
  } pixel_beat_t;

  typedef enum logic { ROW_CFG, ROW_PIX } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] value;
    pixel_beat_t           stim;
    bit                    typed;
    pixel_t                want;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  logic [CFG_DATA_W-1:0] coef_shadow [NPLANE] = '{default: '0};
  offset_t               offset_shadow [NPLANE] = '{default: '0};
  logic [DEPTH_W-1:0]    src_depth_shadow = DEPTH_W'(MIN_DEPTH);
  logic [DEPTH_W-1:0]    dst_depth_shadow = DEPTH_W'(MIN_DEPTH);

  pixel_beat_t expected_pixels [$];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles    = 0;
  int          mismatch_cnt   = 0;
  int          result_cnt     = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  color_matrix_3x4_fixed_point u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // in_sample_0, in_sample_1, in_sample_2
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_sample_0, out_sample_1, out_sample_2
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic int unsigned clamp_depth(logic [DEPTH_W-1:0] d);
    if (d < MIN_DEPTH) return MIN_DEPTH;
    if (d > MAX_DEPTH) return MAX_DEPTH;
    return d;
  endfunction

  function automatic pixel_beat_t convert_pixel(pixel_beat_t req);
    int unsigned sd;
    int unsigned dd;
    int unsigned shamt;
    longint      acc;
    longint      ceiling;
    pixel_beat_t res;
    sd      = clamp_depth(src_depth_shadow);
    dd      = clamp_depth(dst_depth_shadow);
    shamt   = FRAC_BITS + sd - dd;
    ceiling = (longint'(1) << dd) - 1;
    for (int p = 0; p < NPLANE; p++) begin
      acc = longint'(offset_shadow[p]);
      for (int k = 0; k < NPLANE; k++) begin
        acc += longint'(req.smp[k]) * longint'(coef_t'(coef_shadow[p][COEF_W*k +: COEF_W]));
      end
      acc = acc >>> shamt;
      if (acc < 0) begin
        acc = 0;
      end else if (acc > ceiling) begin
        acc = ceiling;
      end
      res.smp[p] = acc[SAMPLE_W-1:0];
    end
    res.last = req.last;
    return res;
  endfunction

  function automatic pixel_t px(sample_t s0, sample_t s1, sample_t s2);
    pixel_t r;
    r[0] = s0;
    r[1] = s1;
    r[2] = s2;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] coefs(coef_t c0, coef_t c1, coef_t c2);
    return {c2, c1, c0};
  endfunction

  function automatic dir_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.value   = value;
    r.stim    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic dir_row_t pix_row(pixel_t smp, logic last, bit typed, pixel_t want);
    dir_row_t r;
    r.kind      = ROW_PIX;
    r.reg_idx   = REG_COEF_ROW0;
    r.value     = '0;
    r.stim.smp  = smp;
    r.stim.last = last;
    r.typed     = typed;
    r.want      = want;
    return r;
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return DEPTH_W'($urandom_range(MAX_DEPTH, MIN_DEPTH));
    if (pick < 80) return DEPTH_W'(MIN_DEPTH);
    if (pick < 90) return DEPTH_W'(MAX_DEPTH);
    return DEPTH_W'($urandom_range(31));
  endfunction

  function automatic pixel_beat_t random_pixel();
    pixel_beat_t r;
    int unsigned sd;
    int unsigned pick;
    sd = clamp_depth(src_depth_shadow);
    for (int k = 0; k < NPLANE; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        r.smp[k] = sample_t'($urandom_range((1 << sd) - 1));
      end else if (pick < 85) begin
        r.smp[k] = sample_t'($urandom);
      end else begin
        case ($urandom_range(2))
          0:       r.smp[k] = '0;
          1:       r.smp[k] = '1;
          default: r.smp[k] = sample_t'((1 << sd) - 1);
        endcase
      end
    end
    r.last = ($urandom_range(15) == 0);
    return r;
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_COEF_ROW0, REG_COEF_ROW1, REG_COEF_ROW2:
        coef_shadow[int'(idx)] = value;
      REG_OFFSET_ROW0, REG_OFFSET_ROW1, REG_OFFSET_ROW2:
        offset_shadow[int'(idx) - int'(REG_OFFSET_ROW0)] = value[OFFSET_W-1:0];
      REG_SOURCE_DEPTH: src_depth_shadow = value[DEPTH_W-1:0];
      REG_DEST_DEPTH:   dst_depth_shadow = value[DEPTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] row;
    logic [COEF_W-1:0]     c;
    logic [OFFSET_W-1:0]   ofs;
    int unsigned           pick;
    for (int p = 0; p < NPLANE; p++) begin
      for (int k = 0; k < NPLANE; k++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          c = COEF_W'($urandom_range(16384) - 8192);
        end else if (pick < 80) begin
          c = COEF_W'($urandom);
        end else begin
          case ($urandom_range(3))
            0:       c = 16'h0000;
            1:       c = 16'h1000;
            2:       c = 16'h7FFF;
            default: c = 16'h8000;
          endcase
        end
        row[COEF_W*k +: COEF_W] = c;
      end
      write_reg(cfg_reg_t'(int'(REG_COEF_ROW0) + p), row);
      pick = $urandom_range(99);
      if (pick < 50) begin
        ofs = OFFSET_W'($urandom_range(1 << 21) - (1 << 20));
      end else if (pick < 75) begin
        ofs = $urandom;
      end else begin
        case ($urandom_range(3))
          0:       ofs = 32'h0000_0000;
          1:       ofs = 32'h7FFF_FFFF;
          2:       ofs = 32'h8000_0000;
          default: ofs = 32'h0000_0800;
        endcase
      end
      write_reg(cfg_reg_t'(int'(REG_OFFSET_ROW0) + p), {16'($urandom), ofs});
    end
    row = {16'($urandom), $urandom};
    row[DEPTH_W-1:0] = pick_depth();
    write_reg(REG_SOURCE_DEPTH, row);
    row = {16'($urandom), $urandom};
    row[DEPTH_W-1:0] = pick_depth();
    write_reg(REG_DEST_DEPTH, row);
  endtask

  task automatic push_pixel(pixel_beat_t req, bit typed, pixel_t want);
    pixel_beat_t exp_beat;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req.smp;
    in_tlast  <= req.last;
    do @(posedge clk); while (!in_tready);
    exp_beat = convert_pixel(req);
    if (typed) exp_beat.smp = want;
    expected_pixels.push_back(exp_beat);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    pixel_beat_t want;
    pixel_beat_t got;
    got.smp  = out_tdata;
    got.last = out_tlast;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        if (mismatch_cnt < 10) begin
          $display("result %0d: nothing expected, got %h %h %h last %b", result_cnt,
                   got.smp[0], got.smp[1], got.smp[2], got.last);
        end
        mismatch_cnt++;
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          if (mismatch_cnt < 10) begin
            $display("result %0d: expected %h %h %h last %b, got %h %h %h last %b",
                     result_cnt, want.smp[0], want.smp[1], want.smp[2], want.last,
                     got.smp[0], got.smp[1], got.smp[2], got.last);
          end
          mismatch_cnt++;
        end
      end
      result_cnt++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    dir_row_t rows [$];
    rows.push_back(pix_row(px(16'h0000, 16'h0000, 16'h0000), 1'b0, 1'b1, px('0, '0, '0)));
    rows.push_back(pix_row(px(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 1'b1, px('0, '0, '0)));
    rows.push_back(cfg_row(REG_OFFSET_ROW0, 48'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_OFFSET_ROW1, 48'h8000_0000));
    rows.push_back(pix_row(px(16'h0000, 16'h0000, 16'h0000), 1'b0, 1'b1, px(16'hFF, '0, '0)));
    rows.push_back(pix_row(px(16'hFFFF, 16'h8000, 16'h0001), 1'b1, 1'b1, px(16'hFF, '0, '0)));
    rows.push_back(cfg_row(REG_OFFSET_ROW0, 48'h0));
    rows.push_back(cfg_row(REG_OFFSET_ROW1, 48'h0));
    rows.push_back(cfg_row(REG_COEF_ROW0, coefs(16'h1000, 16'h0000, 16'h0000)));
    rows.push_back(cfg_row(REG_COEF_ROW1, coefs(16'h0000, 16'h1000, 16'h0000)));
    rows.push_back(cfg_row(REG_COEF_ROW2, coefs(16'h0000, 16'h0000, 16'h1000)));
    rows.push_back(pix_row(px(16'h12, 16'h34, 16'h56), 1'b0, 1'b1, px(16'h12, 16'h34, 16'h56)));
    rows.push_back(pix_row(px(16'hFF, 16'h00, 16'h80), 1'b0, 1'b1, px(16'hFF, 16'h00, 16'h80)));
    // samples above the source depth are used unmasked and clamp
    rows.push_back(pix_row(px(16'hFFFF, 16'h100, 16'h1FF), 1'b1, 1'b1,
                           px(16'hFF, 16'hFF, 16'hFF)));
    // negative offset rounds toward minus infinity
    rows.push_back(cfg_row(REG_OFFSET_ROW1, 48'hFFFF_FFFF));
    rows.push_back(pix_row(px(16'h5, 16'h5, 16'h0), 1'b0, 1'b1, px(16'h5, 16'h4, 16'h0)));
    rows.push_back(cfg_row(REG_OFFSET_ROW1, 48'h0));
    rows.push_back(cfg_row(REG_DEST_DEPTH, 48'd16));
    rows.push_back(cfg_row(REG_SOURCE_DEPTH, 48'd16));
    rows.push_back(pix_row(px(16'hFFFF, 16'h8000, 16'h0001), 1'b1, 1'b1,
                           px(16'hFFFF, 16'h8000, 16'h0001)));
    rows.push_back(cfg_row(REG_COEF_ROW0, coefs(16'h8000, 16'h8000, 16'h8000)));
    rows.push_back(cfg_row(REG_COEF_ROW1, coefs(16'h7FFF, 16'h7FFF, 16'h7FFF)));
    rows.push_back(cfg_row(REG_COEF_ROW2, coefs(16'h7FFF, 16'h8000, 16'h0800)));
    rows.push_back(pix_row(px(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 1'b0, '0));
    rows.push_back(pix_row(px(16'h0001, 16'h0002, 16'h0003), 1'b0, 1'b0, '0));
    // depths outside 8..16 saturate
    rows.push_back(cfg_row(REG_SOURCE_DEPTH, 48'd0));
    rows.push_back(cfg_row(REG_DEST_DEPTH, 48'd31));
    rows.push_back(pix_row(px(16'hFFFF, 16'h0000, 16'h0000), 1'b0, 1'b0, '0));
    rows.push_back(pix_row(px(16'h0000, 16'hFFFF, 16'hFFFF), 1'b1, 1'b0, '0));
    rows.push_back(pix_row(px(16'h1234, 16'h5678, 16'h9ABC), 1'b0, 1'b0, '0));
    rows.push_back(cfg_row(REG_SOURCE_DEPTH, 48'd31));
    rows.push_back(cfg_row(REG_DEST_DEPTH, 48'd0));
    rows.push_back(cfg_row(REG_OFFSET_ROW2, 48'h0008_0000));
    rows.push_back(pix_row(px(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, 1'b0, '0));
    rows.push_back(pix_row(px(16'h0001, 16'h8000, 16'h7FFF), 1'b1, 1'b0, '0));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].reg_idx, rows[i].value);
      end else begin
        push_pixel(rows[i].stim, rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_setup();
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        // hold the sender until the pipe is empty
        if (n == PHASE_REQS / 2) wait_drained();
        push_pixel(random_pixel(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
